### src/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SCT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must hold in the cycle after the antecedent
`define SCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/sct_pkg.sv
// shared constants and types for the sine/cosine series pipeline
package sct_pkg;

	// fraction bits of the series arithmetic
	localparam int INT_FRAC = 50;
	// 2*pi scaled by 2^60, truncated
	localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;
	// modular doubling steps done in one reduction stage
	localparam int RED_STEPS_PER_STAGE = 4;
	// number of series terms after the leading one
	localparam int NUM_TERMS = 10;
	// reciprocal width and shift for exact division by k*(k-1) <= 512
	localparam int RECIP_W = 72;
	localparam int RECIP_SHIFT = 72;

	// item traveling down the term chain
	typedef struct packed {
		logic        vld;
		logic        func;
		logic [63:0] t;
		logic [63:0] x2;
		logic [63:0] acc;
	} term_bus_t;

endpackage

### src/sct_mul.sv
// two-stage unsigned multiplier built from registered 32x32 partial products
module sct_mul import sct_pkg::*; #(
	parameter int AW = 64,
	parameter int BW = 64
) (
	input  logic              clk,
	input  logic              en,
	input  logic [AW-1:0]     a,
	input  logic [BW-1:0]     b,
	output logic [AW+BW-1:0]  p
);

	localparam int NA = (AW + 31) / 32;
	localparam int NB = (BW + 31) / 32;
	localparam int PW = AW + BW;

	logic [NA*32-1:0] ax;
	logic [NB*32-1:0] bx;
	logic [63:0]      pp_s1 [NA][NB];
	logic [PW-1:0]    sum;

	assign ax = (NA*32)'(a);
	assign bx = (NB*32)'(b);

	// partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= 64'(ax[i*32 +: 32]) * 64'(bx[j*32 +: 32]);
				end
			end
		end
	end

	// weighted sum of the partials
	always_comb begin
		sum = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				sum = sum + (PW'(pp_s1[i][j]) << (32 * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= sum;
		end
	end

endmodule

### src/sct_term.sv
// series term: t = floor(floor(t*x2/2^50)/(k*(k-1))), added or subtracted in acc
module sct_term import sct_pkg::*; #(
	parameter int J = 1
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  term_bus_t bus_in,
	output term_bus_t bus_out
);

	localparam int D_SIN = (2 * J + 1) * (2 * J);
	localparam int D_COS = (2 * J) * (2 * J - 1);
	localparam logic [79:0] M_SIN_W =
		((80'd1 << RECIP_SHIFT) + 80'(D_SIN) - 80'd1) / 80'(D_SIN);
	localparam logic [79:0] M_COS_W =
		((80'd1 << RECIP_SHIFT) + 80'(D_COS) - 80'd1) / 80'(D_COS);
	localparam logic [RECIP_W-1:0] M_SIN = M_SIN_W[RECIP_W-1:0];
	localparam logic [RECIP_W-1:0] M_COS = M_COS_W[RECIP_W-1:0];
	// sine has one term fewer than cosine
	localparam bit SIN_SKIP = (J == NUM_TERMS);
	localparam bit SUBTRACT = (J % 2 == 1);

	term_bus_t               bus_s1, bus_s2, bus_s3, bus_s4;
	logic [127:0]            prod_a;
	logic [63:0]             num;
	logic [RECIP_W-1:0]      recip;
	logic [64+RECIP_W-1:0]   prod_b;
	logic [63:0]             quo;
	logic                    skip;

	// t * x2
	sct_mul #(.AW(64), .BW(64)) u_mul_t (
		.clk (clk),
		.en  (en),
		.a   (bus_in.t),
		.b   (bus_in.x2),
		.p   (prod_a)
	);

	assign num   = prod_a[113:INT_FRAC];
	assign recip = bus_s2.func ? M_COS : M_SIN;

	// division by k*(k-1) as multiplication by its reciprocal
	sct_mul #(.AW(64), .BW(RECIP_W)) u_mul_div (
		.clk (clk),
		.en  (en),
		.a   (num),
		.b   (recip),
		.p   (prod_b)
	);

	assign quo  = prod_b[64+RECIP_W-1:RECIP_SHIFT];
	assign skip = SIN_SKIP && !bus_s4.func;

	// sideband delay and accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_s1.vld  <= 1'b0;
			bus_s2.vld  <= 1'b0;
			bus_s3.vld  <= 1'b0;
			bus_s4.vld  <= 1'b0;
			bus_out.vld <= 1'b0;
		end else if (en) begin
			bus_s1       <= bus_in;
			bus_s2       <= bus_s1;
			bus_s3       <= bus_s2;
			bus_s4       <= bus_s3;
			bus_out.vld  <= bus_s4.vld;
			bus_out.func <= bus_s4.func;
			bus_out.x2   <= bus_s4.x2;
			bus_out.t    <= quo;
			if (skip) begin
				bus_out.acc <= bus_s4.acc;
			end else if (SUBTRACT) begin
				bus_out.acc <= bus_s4.acc - quo;
			end else begin
				bus_out.acc <= bus_s4.acc + quo;
			end
		end
	end

endmodule

### src/sine_cosine_taylor.sv
// Path from input transfer to result: input register, reduction stages (4 reduction
// steps per stage), the x^2 multiplier, the series term chain and the output register.
// Throughput: one item per cycle; the whole pipeline holds while the result waits.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
`include "assert_macros.svh"

// sine or cosine of a fixed-point angle by truncated maclaurin series
module sine_cosine_taylor import sct_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 16,
	parameter int OUT_FRAC_BITS = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] angle
	input  logic        s_axis_tuser,  // [0] func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // [31:0] value
);

	localparam int NSTEP = 60 - ANGLE_FRAC_BITS;
	localparam int NRED = (NSTEP + RED_STEPS_PER_STAGE - 1) / RED_STEPS_PER_STAGE;
	localparam int SH = INT_FRAC - OUT_FRAC_BITS;
	localparam logic signed [63:0] SAT_HI = 64'sh7FFF_FFFF;
	localparam logic signed [63:0] SAT_LO = -64'sh8000_0000;

	logic              adv;
	logic [31:0]       neg_mag;
	logic [63:0]       red_m_r   [NRED+1];
	logic [NRED:0]     red_vld;
	logic [NRED:0]     red_func;
	logic [63:0]       x;
	logic [127:0]      x_sq;
	logic [63:0]       x_s1, x_s2;
	logic              vld_s1, vld_s2, func_s1, func_s2;
	term_bus_t         bus [NUM_TERMS+1];
	logic [63:0]       rnd;
	logic signed [63:0] shf;

	// global stall: everything moves when the output slot is free
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// input register, folds a negative angle to 2*pi - |angle|
	assign neg_mag = ~s_axis_tdata + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_vld[0] <= 1'b0;
		end else if (adv) begin
			red_vld[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_func[0] <= s_axis_tuser;
			red_m_r[0]  <= s_axis_tdata[31] ? TWO_PI_Q60 - {32'd0, neg_mag}
			                                : {32'd0, s_axis_tdata};
		end
	end

	// modular doubling stages
	for (genvar g = 0; g < NRED; g++) begin : g_red
		logic [63:0] m;

		always_comb begin
			m = red_m_r[g];
			for (int k = 0; k < RED_STEPS_PER_STAGE; k++) begin
				if (g * RED_STEPS_PER_STAGE + k < NSTEP) begin
					m = m << 1;
					if (m >= TWO_PI_Q60) begin
						m = m - TWO_PI_Q60;
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				red_vld[g+1] <= 1'b0;
			end else if (adv) begin
				red_vld[g+1] <= red_vld[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				red_func[g+1]  <= red_func[g];
				red_m_r[g+1]   <= m;
			end
		end
	end

	// x in q.50 and its square
	assign x = {10'd0, red_m_r[NRED][63:10]};

	sct_mul #(.AW(64), .BW(64)) u_mul_sq (
		.clk (clk),
		.en  (adv),
		.a   (x),
		.b   (x),
		.p   (x_sq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= red_vld[NRED];
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= red_func[NRED];
			func_s2 <= func_s1;
			x_s1    <= x;
			x_s2    <= x_s1;
		end
	end

	// leading term: x for sine, one for cosine
	always_comb begin
		bus[0].vld  = vld_s2;
		bus[0].func = func_s2;
		bus[0].x2   = x_sq[113:INT_FRAC];
		bus[0].t    = func_s2 ? (64'd1 << INT_FRAC) : x_s2;
		bus[0].acc  = bus[0].t;
	end

	// series term chain
	for (genvar j = 1; j <= NUM_TERMS; j++) begin : g_term
		sct_term #(.J(j)) u_term (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.bus_in  (bus[j-1]),
			.bus_out (bus[j])
		);
	end

	// round half up, shift and saturate
	assign rnd = bus[NUM_TERMS].acc + (64'd1 << (SH - 1));
	assign shf = $signed(rnd) >>> SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			m_axis_tvalid <= bus[NUM_TERMS].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (shf > SAT_HI) begin
				m_axis_tdata <= 32'h7FFF_FFFF;
			end else if (shf < SAT_LO) begin
				m_axis_tdata <= 32'h8000_0000;
			end else begin
				m_axis_tdata <= shf[31:0];
			end
		end
	end

	// checks
	`SCT_ASSERT(a_red_range, !red_vld[NRED] || (red_m_r[NRED] < TWO_PI_Q60), "reduced angle not below 2*pi")
	`SCT_ASSERT(a_x2_range, !bus[0].vld || (bus[0].x2 < (64'd40 << INT_FRAC)), "x squared out of range")
	`SCT_ASSERT_NEXT(a_stall_hold, !adv, $stable(red_vld), "reduction valids moved during stall")

endmodule

### tb/tb_sine_cosine_taylor.sv
// self-checking testbench for the sine/cosine series pipeline
module tb_sine_cosine_taylor;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ANGLE_FRAC_BITS = 16;
	localparam int OUT_FRAC_BITS = 30;
	localparam logic FUNC_SIN = 1'b0;
	localparam logic FUNC_COS = 1'b1;
	localparam int NUM_RANDOM = 1950;
	localparam int DRAIN_CYCLES = 120;
	localparam int STALL_LIMIT = 4000;
	localparam logic [63:0] TWO_PI = 64'h6487_ED51_10B4_611A;

	// expected values of the series, oldest first
	class trig_scoreboard;
		logic [31:0] pending_values[$];
		int errors;
		int sin_count;
		int cos_count;

		// fixed-point multiply in q.50, truncated
		function automatic logic [63:0] mulq(logic [63:0] a, logic [63:0] b);
			logic [127:0] p;
			p = a * b;
			return p[113:50];
		endfunction

		// floored reduction into [0, 2*pi), returned in q.50
		function automatic logic [63:0] reduce(logic [31:0] raw);
			logic [63:0] m;
			if (raw[31])
				m = TWO_PI - (64'h1_0000_0000 - {32'd0, raw});
			else
				m = {32'd0, raw};
			for (int i = 0; i < 60 - ANGLE_FRAC_BITS; i++) begin
				m = m << 1;
				if (m >= TWO_PI)
					m = m - TWO_PI;
			end
			return m >> 10;
		endfunction

		function automatic logic [31:0] series(logic [31:0] angle, logic func);
			logic [63:0] x, x2, t, acc;
			logic signed [63:0] r;
			int first, last;
			bit neg;
			x = reduce(angle);
			x2 = mulq(x, x);
			if (func == FUNC_COS) begin
				t = 64'd1 << 50;
				first = 2;
				last = 20;
			end else begin
				t = x;
				first = 3;
				last = 19;
			end
			acc = t;
			neg = 1;
			for (int k = first; k <= last; k += 2) begin
				t = mulq(t, x2) / (k * (k - 1));
				acc = neg ? acc - t : acc + t;
				neg = !neg;
			end
			// round half up, then saturate to 32 bits
			acc = acc + (64'd1 << (49 - OUT_FRAC_BITS));
			r = $signed(acc) >>> (50 - OUT_FRAC_BITS);
			if (r > 64'sh7FFF_FFFF)
				return 32'h7FFF_FFFF;
			if (r < -64'sh8000_0000)
				return 32'h8000_0000;
			return r[31:0];
		endfunction

		function void note_angle(logic [31:0] angle, logic func);
			pending_values.push_back(series(angle, func));
			if (func == FUNC_COS)
				cos_count++;
			else
				sin_count++;
		endfunction

		function void check_value(logic [31:0] value);
			logic [31:0] want;
			if (pending_values.size() == 0) begin
				$display("%0t: unexpected result %h", $time, value);
				errors++;
				return;
			end
			want = pending_values.pop_front();
			if (value !== want) begin
				$display("%0t: value mismatch expected %h actual %h", $time, want, value);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;  // [31:0] angle
	logic        s_axis_tuser;  // [0] func
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;  // [31:0] value

	trig_scoreboard sb;
	int idle_cycles;
	bit burst_mode;

	sine_cosine_taylor #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int draw_gap();
		return burst_mode ? 0 : $urandom_range(0, 7);
	endfunction

	// present one angle and hold it until the transfer
	task automatic send_angle(logic [31:0] angle, logic func);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= angle;
		s_axis_tuser <= func;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// result side back-pressure
	task automatic accept_results();
		int gap;
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	endtask

	// monitor both transfers and watch for a stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_angle(s_axis_tdata, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_value(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("tb_sine_cosine_taylor: FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] corner[] = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'hFFFF_FFFF, 32'h0000_0001, 32'h0003_243F, 32'hFFFC_DBC1,
			32'h0006_487E, 32'h0006_487F, 32'hFFF9_B781, 32'h0001_921F,
			32'h0004_B65F};
		logic [31:0] angle;
		sb = new();
		idle_cycles = 0;
		burst_mode = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			accept_results();
		join_none

		// corner angles, both functions
		foreach (corner[i]) begin
			send_angle(corner[i], FUNC_SIN);
			send_angle(corner[i], FUNC_COS);
		end

		// random angles, mostly within one turn either way, some over the full range
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n % 100 == 0)
				burst_mode = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) == 0)
				angle = $urandom();
			else
				angle = $urandom_range(0, 32'h000C_9100) - 32'h0006_4880;
			send_angle(angle, 1'($urandom_range(0, 1)));
		end
		s_axis_tvalid <= 1'b0;
		burst_mode = 0;

		// drain the pipeline
		while (sb.pending_values.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d sine and %0d cosine angles, corners and random, with stalls",
			sb.sin_count, sb.cos_count);
		if (sb.errors == 0)
			$display("tb_sine_cosine_taylor: PASS");
		else
			$display("tb_sine_cosine_taylor: FAIL");
		$finish;
	end
endmodule

### filelist.f
+incdir+src
src/sct_pkg.sv
src/sct_mul.sv
src/sct_term.sv
src/sine_cosine_taylor.sv
tb/tb_sine_cosine_taylor.sv
